// File: design/ctsc_pkg.sv
// ----------------------------------------------------------------------------
// ctsc_pkg
// Types and constants shared by the clock time-set controller modules.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam logic [1:0] ACT_SHORT  = 2'd0;
  localparam logic [1:0] ACT_LONG   = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  localparam logic [1:0] DIG_HOUR_TENS = 2'd0;
  localparam logic [1:0] DIG_HOUR_ONES = 2'd1;
  localparam logic [1:0] DIG_MIN_TENS  = 2'd2;
  localparam logic [1:0] DIG_MIN_ONES  = 2'd3;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] report_hour;
    logic [5:0] report_minute;
  } in_t;

  typedef struct packed {
    logic       editing;
    logic [1:0] selected_digit;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic       commit_time;
    logic       edit_entered;
  } out_t;

endpackage

// File: design/ctsc_digit.sv
// ----------------------------------------------------------------------------
// ctsc_digit
// Advances one decimal digit of the edit time for a short key press.
// ----------------------------------------------------------------------------
module ctsc_digit (
  input  logic [1:0] digit_i,
  input  logic [4:0] hour_i,
  input  logic [5:0] minute_i,
  output logic [4:0] hour_o,
  output logic [5:0] minute_o
);

  logic [1:0] h_tens;
  logic [3:0] h_ones;
  logic [2:0] m_tens;
  logic [3:0] m_ones;
  logic [1:0] h_tens_inc;
  logic [3:0] h_ones_inc;
  logic [2:0] m_tens_inc;
  logic [3:0] m_ones_inc;
  logic [4:0] h_base;
  logic [5:0] m_base;

  always_comb begin
    if (hour_i >= 5'd20) begin
      h_tens = 2'd2;
    end else if (hour_i >= 5'd10) begin
      h_tens = 2'd1;
    end else begin
      h_tens = 2'd0;
    end
    h_base = 5'(h_tens) * 5'd10;
    h_ones = 4'(hour_i - h_base);

    if (minute_i >= 6'd50) begin
      m_tens = 3'd5;
    end else if (minute_i >= 6'd40) begin
      m_tens = 3'd4;
    end else if (minute_i >= 6'd30) begin
      m_tens = 3'd3;
    end else if (minute_i >= 6'd20) begin
      m_tens = 3'd2;
    end else if (minute_i >= 6'd10) begin
      m_tens = 3'd1;
    end else begin
      m_tens = 3'd0;
    end
    m_base = 6'(m_tens) * 6'd10;
    m_ones = 4'(minute_i - m_base);

    h_tens_inc = (h_tens >= 2'd2) ? 2'd0 : h_tens + 2'd1;
    h_ones_inc = (h_ones >= 4'd9) ? 4'd0 : h_ones + 4'd1;
    m_tens_inc = (m_tens >= 3'd5) ? 3'd0 : m_tens + 3'd1;
    m_ones_inc = (m_ones >= 4'd9) ? 4'd0 : m_ones + 4'd1;

    hour_o   = hour_i;
    minute_o = minute_i;
    case (digit_i)
      ctsc_pkg::DIG_HOUR_TENS: begin
        if (h_tens_inc == 2'd2 && h_ones > 4'd3) begin
          hour_o = ctsc_pkg::MAX_HOUR;
        end else begin
          hour_o = 5'(h_tens_inc) * 5'd10 + 5'(h_ones);
        end
      end
      ctsc_pkg::DIG_HOUR_ONES: begin
        if (h_tens == 2'd2 && h_ones_inc > 4'd3) begin
          hour_o = h_base;
        end else begin
          hour_o = h_base + 5'(h_ones_inc);
        end
      end
      ctsc_pkg::DIG_MIN_TENS: begin
        minute_o = 6'(m_tens_inc) * 6'd10 + 6'(m_ones);
      end
      ctsc_pkg::DIG_MIN_ONES: begin
        minute_o = m_base + 6'(m_ones_inc);
      end
      default: begin
        hour_o   = hour_i;
        minute_o = minute_i;
      end
    endcase
  end

endmodule

// File: design/clock_time_set_controller_core.sv
// ----------------------------------------------------------------------------
// clock_time_set_controller_core
// One-button clock time-setting controller with a display mode and an edit mode.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer. An item is captured
// in an input register, the mode and digit logic runs in the following cycle
// and the result lands in an output register; one item is taken every cycle
// while the output side does not stall. The block is limited by the state
// update, which each item's result depends on.
module clock_time_set_controller_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ctsc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ctsc_pkg::out_t  out_data_o
);

  logic           in_valid_q;
  ctsc_pkg::in_t  in_q;
  logic           out_valid_q;
  ctsc_pkg::out_t out_q;
  ctsc_pkg::out_t out_d;

  logic       edit_q, edit_d;
  logic [1:0] digit_q, digit_d;
  logic [4:0] held_hour_q, held_hour_d;
  logic [5:0] held_min_q, held_min_d;
  logic [4:0] edit_hour_q, edit_hour_d;
  logic [5:0] edit_min_q, edit_min_d;
  logic [4:0] adv_hour;
  logic [5:0] adv_min;

  logic out_free;
  logic step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  ctsc_digit u_digit (
    .digit_i  (digit_q),
    .hour_i   (edit_hour_q),
    .minute_i (edit_min_q),
    .hour_o   (adv_hour),
    .minute_o (adv_min)
  );

  always_comb begin
    edit_d      = edit_q;
    digit_d     = digit_q;
    held_hour_d = held_hour_q;
    held_min_d  = held_min_q;
    edit_hour_d = edit_hour_q;
    edit_min_d  = edit_min_q;
    out_d       = '0;
    if (!edit_q) begin
      if (in_q.action == ctsc_pkg::ACT_REPORT) begin
        held_hour_d = (in_q.report_hour > ctsc_pkg::MAX_HOUR) ?
                      ctsc_pkg::MAX_HOUR : in_q.report_hour;
        held_min_d  = (in_q.report_minute > ctsc_pkg::MAX_MINUTE) ?
                      ctsc_pkg::MAX_MINUTE : in_q.report_minute;
      end else if (in_q.action == ctsc_pkg::ACT_LONG) begin
        edit_d             = 1'b1;
        digit_d            = ctsc_pkg::DIG_HOUR_TENS;
        edit_hour_d        = held_hour_q;
        edit_min_d         = held_min_q;
        out_d.edit_entered = 1'b1;
      end
    end else begin
      if (in_q.action == ctsc_pkg::ACT_SHORT) begin
        edit_hour_d = adv_hour;
        edit_min_d  = adv_min;
      end else if (in_q.action == ctsc_pkg::ACT_LONG) begin
        if (digit_q == ctsc_pkg::DIG_MIN_ONES) begin
          held_hour_d       = edit_hour_q;
          held_min_d        = edit_min_q;
          edit_d            = 1'b0;
          out_d.commit_time = 1'b1;
        end else begin
          digit_d = digit_q + 2'd1;
        end
      end
    end
    out_d.editing        = edit_d;
    out_d.selected_digit = edit_d ? digit_d : ctsc_pkg::DIG_HOUR_TENS;
    out_d.shown_hour     = edit_d ? edit_hour_d : held_hour_d;
    out_d.shown_minute   = edit_d ? edit_min_d : held_min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      edit_q      <= 1'b0;
      digit_q     <= '0;
      held_hour_q <= '0;
      held_min_q  <= '0;
      edit_hour_q <= '0;
      edit_min_q  <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        edit_q      <= edit_d;
        digit_q     <= digit_d;
        held_hour_q <= held_hour_d;
        held_min_q  <= held_min_d;
        edit_hour_q <= edit_hour_d;
        edit_min_q  <= edit_min_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_commit_leaves_edit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.commit_time |-> !out_q.editing)
    else $error("commit result still in edit mode");

  a_enter_at_hour_tens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.edit_entered |->
      out_q.editing && out_q.selected_digit == ctsc_pkg::DIG_HOUR_TENS)
    else $error("edit entry not at hour tens");

  a_shown_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.shown_hour <= ctsc_pkg::MAX_HOUR &&
      out_q.shown_minute <= ctsc_pkg::MAX_MINUTE)
    else $error("shown time out of range");

  a_state_holds_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(edit_q) && $stable(digit_q) && $stable(held_hour_q))
    else $error("state changed without a transfer");

endmodule
